### sv/ftrt_pkg.sv
// shared types and constants for the footswitch relay toggle block
`timescale 1ns / 1ps
`default_nettype none

package ftrt_pkg;

	// register file layout
	localparam int REG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MUTE_HALF       = 1'b1;

	// register reset values
	localparam logic [REG_W-1:0] PRESS_THRESHOLD_RESET = 16'd1750;
	localparam logic [REG_W-1:0] MUTE_HALF_RESET       = 16'd7;

	// debounce counter width
	localparam int COUNTER_BITS_DEFAULT = 16;

	// mute sequence phase
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	// accepted presses on one tick
	typedef struct packed {
		logic press_a;
		logic press_b;
	} press_t;

	// state shown in one result item
	typedef struct packed {
		logic effect_a;
		logic effect_b;
		logic muting;
	} status_t;

endpackage

`default_nettype wire

### sv/ftrt_debounce.sv
// up/down debounce counter and press latch for one footswitch
`timescale 1ns / 1ps
`default_nettype none

module ftrt_debounce #(
	parameter int COUNTER_BITS = ftrt_pkg::COUNTER_BITS_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       enable,
	input  wire logic                       level,
	input  wire logic [ftrt_pkg::REG_W-1:0] threshold,
	output logic                            press
);

	localparam int CMP_W = (COUNTER_BITS > ftrt_pkg::REG_W) ? COUNTER_BITS : ftrt_pkg::REG_W;

	logic [COUNTER_BITS-1:0] count_q, count_d;
	logic                    latch_q, latch_d;
	logic                    below;

	// below threshold and not saturated
	assign below = (CMP_W'(count_q) < CMP_W'(threshold)) && (count_q != {COUNTER_BITS{1'b1}});

	// next count and latch
	always_comb begin
		count_d = count_q;
		latch_d = latch_q;
		press   = 1'b0;
		if (enable) begin
			if (!level && !latch_q) begin
				if (below) begin
					count_d = count_q + COUNTER_BITS'(1);
				end else begin
					count_d = '0;
					latch_d = 1'b1;
					press   = 1'b1;
				end
			end else if (level) begin
				if (count_q == '0) begin
					latch_d = 1'b0;
				end else begin
					count_d = count_q - COUNTER_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			latch_q <= 1'b0;
		end else begin
			count_q <= count_d;
			latch_q <= latch_d;
		end
	end

endmodule

`default_nettype wire

### sv/ftrt_sequencer.sv
// mute pulse sequencer and effect toggles for both channels
`timescale 1ns / 1ps
`default_nettype none

module ftrt_sequencer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       enable,
	input  wire ftrt_pkg::press_t           press,
	input  wire logic [ftrt_pkg::REG_W-1:0] half_ticks,
	output logic                            idle,
	output ftrt_pkg::status_t               status_nxt
);

	ftrt_pkg::phase_t phase_q, phase_d;
	logic [ftrt_pkg::REG_W-1:0] timer_q, timer_d, timer_inc, half;
	logic active_q, active_d;
	logic b_wait_q, b_wait_d;
	logic eff_a_q, eff_a_d;
	logic eff_b_q, eff_b_d;
	logic done;

	// zero half time acts as one
	assign half      = (half_ticks == '0) ? ftrt_pkg::REG_W'(1) : half_ticks;
	assign timer_inc = timer_q + ftrt_pkg::REG_W'(1);
	assign done      = timer_inc >= half;

	// next state
	always_comb begin
		phase_d  = phase_q;
		timer_d  = timer_q;
		active_d = active_q;
		b_wait_d = b_wait_q;
		eff_a_d  = eff_a_q;
		eff_b_d  = eff_b_q;
		if (enable) begin
			case (phase_q)
				ftrt_pkg::PH_FIRST: begin
					timer_d = timer_inc;
					if (done) begin
						if (active_q) begin
							eff_b_d = ~eff_b_q;
						end else begin
							eff_a_d = ~eff_a_q;
						end
						phase_d = ftrt_pkg::PH_SECOND;
						timer_d = '0;
					end
				end
				ftrt_pkg::PH_SECOND: begin
					timer_d = timer_inc;
					if (done) begin
						timer_d = '0;
						if (b_wait_q) begin
							b_wait_d = 1'b0;
							active_d = 1'b1;
							phase_d  = ftrt_pkg::PH_FIRST;
						end else begin
							phase_d = ftrt_pkg::PH_IDLE;
						end
					end
				end
				default: begin
					if (press.press_a) begin
						phase_d  = ftrt_pkg::PH_FIRST;
						timer_d  = '0;
						active_d = 1'b0;
						b_wait_d = press.press_b;
					end else if (press.press_b) begin
						phase_d  = ftrt_pkg::PH_FIRST;
						timer_d  = '0;
						active_d = 1'b1;
						b_wait_d = 1'b0;
					end
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		idle                = !(phase_q == ftrt_pkg::PH_FIRST || phase_q == ftrt_pkg::PH_SECOND);
		status_nxt.effect_a = eff_a_d;
		status_nxt.effect_b = eff_b_d;
		status_nxt.muting   = (phase_d == ftrt_pkg::PH_FIRST || phase_d == ftrt_pkg::PH_SECOND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ftrt_pkg::PH_IDLE;
			timer_q  <= '0;
			active_q <= 1'b0;
			b_wait_q <= 1'b0;
			eff_a_q  <= 1'b0;
			eff_b_q  <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			timer_q  <= timer_d;
			active_q <= active_d;
			b_wait_q <= b_wait_d;
			eff_a_q  <= eff_a_d;
			eff_b_q  <= eff_b_d;
		end
	end

endmodule

`default_nettype wire

### sv/footswitch_relay_toggle_mute.sv
// Each item is registered in the input register, then in the result register.
// Throughput: one item per cycle while results are taken; both registers advance
// together, and an empty input register takes an item while a result waits.
// The per-tick update is a counter compare and step per channel plus the phase timer.
// Reset: asynchronous, active low; counters, latches, effects and phase clear,
// registers return to a threshold of 1750 and a half time of 7 ticks.
`timescale 1ns / 1ps
`default_nettype none

module footswitch_relay_toggle_mute #(
	parameter int COUNTER_BITS = ftrt_pkg::COUNTER_BITS_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ftrt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ftrt_pkg::REG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           button_a_level,
	input  wire logic                           button_b_level,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                relay_a,
	output logic                                led_a,
	output logic                                relay_b,
	output logic                                led_b,
	output logic                                mute_drive
);

	logic [ftrt_pkg::REG_W-1:0] threshold_q, half_q;
	logic valid_s1, level_a_s1, level_b_s1;
	logic valid_s2;
	ftrt_pkg::status_t status_s2, status_nxt;
	ftrt_pkg::press_t  press;
	logic press_a, press_b;
	logic advance, idle, dbnc_en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ftrt_pkg::PRESS_THRESHOLD_RESET;
			half_q      <= ftrt_pkg::MUTE_HALF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ftrt_pkg::CFG_PRESS_THRESHOLD: threshold_q <= cfg_data;
				ftrt_pkg::CFG_MUTE_HALF:       half_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: the item in the input register moves on when the result slot frees
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign dbnc_en  = advance && idle;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_a_s1 <= button_a_level;
			level_b_s1 <= button_b_level;
		end
	end

	ftrt_debounce #(.COUNTER_BITS(COUNTER_BITS)) u_dbnc_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (dbnc_en),
		.level     (level_a_s1),
		.threshold (threshold_q),
		.press     (press_a)
	);

	ftrt_debounce #(.COUNTER_BITS(COUNTER_BITS)) u_dbnc_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (dbnc_en),
		.level     (level_b_s1),
		.threshold (threshold_q),
		.press     (press_b)
	);

	// presses of both channels on this tick
	assign press = {press_a, press_b};

	ftrt_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (advance),
		.press      (press),
		.half_ticks (half_q),
		.idle       (idle),
		.status_nxt (status_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign relay_a    = status_s2.effect_a;
	assign led_a      = status_s2.effect_a;
	assign relay_b    = status_s2.effect_b;
	assign led_b      = status_s2.effect_b;
	assign mute_drive = status_s2.muting;

endmodule

`default_nettype wire

### sv/ftrt_checker.sv
// port-level checks for the footswitch relay toggle block
`timescale 1ns / 1ps
`default_nettype none

module ftrt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic relay_a,
	input wire logic led_a,
	input wire logic relay_b,
	input wire logic led_b,
	input wire logic mute_drive
);

	logic last_a_q, last_b_q, last_mute_q;

	// last delivered result item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q    <= 1'b0;
			last_b_q    <= 1'b0;
			last_mute_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			last_a_q    <= relay_a;
			last_b_q    <= relay_b;
			last_mute_q <= mute_drive;
		end
	end

	// leds follow relays
	a_led_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (led_a == relay_a) && (led_b == relay_b))
		else $error("led differs from relay");

	// a relay only toggles inside a running mute pulse
	a_toggle_a_muted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (relay_a != last_a_q) |-> mute_drive && last_mute_q)
		else $error("relay a toggled outside a mute pulse");

	a_toggle_b_muted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (relay_b != last_b_q) |-> mute_drive && last_mute_q)
		else $error("relay b toggled outside a mute pulse");

	// never both relays toggle between two items
	a_one_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> !((relay_a != last_a_q) && (relay_b != last_b_q)))
		else $error("both relays toggled on one item");

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(relay_a) && $stable(relay_b)
			&& $stable(mute_drive))
		else $error("stalled result changed");

endmodule

bind footswitch_relay_toggle_mute ftrt_checker u_ftrt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.relay_a    (relay_a),
	.led_a      (led_a),
	.relay_b    (relay_b),
	.led_b      (led_b),
	.mute_drive (mute_drive)
);

`default_nettype wire
